>>> design/tac_pkg.sv
// Shared widths, constants and types for the triangle area and centroid pipeline.
package tac_pkg;

  // Field and intermediate widths.
  localparam int COORD_W  = 24;               // vertex coordinate, signed Q12.12
  localparam int EDGE_W   = COORD_W + 1;      // difference of two coordinates
  localparam int SUM_W    = COORD_W + 2;      // sum of three coordinates
  localparam int CMAG_W   = COORD_W + 1;      // magnitude of a coordinate sum
  localparam int PROD_W   = 2 * EDGE_W;       // product of a pair of edge components
  localparam int CROSS_W  = PROD_W + 1;       // cross product component
  localparam int MAG_W    = PROD_W;           // magnitude of a cross component
  localparam int HALF_W   = MAG_W / 2;        // half of a magnitude for the squaring
  localparam int SQ_W     = 2 * MAG_W;        // squared norm
  localparam int AREA_W   = 50;               // area result
  localparam int ROOT_W   = SQ_W / 2;         // square root, one bit per stage
  localparam int REM_W    = ROOT_W + 1;       // partial remainder of the root
  localparam int SQRT_STAGES = ROOT_W;

  // Division by three through a reciprocal: floor(n * RECIP_3 / 2^RECIP_SHIFT)
  // equals floor(n / 3) for every n below 2^RECIP_SHIFT.
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(44739243);
  localparam int QPROD_W     = CMAG_W + RECIP_W;

  // Register stages in front of the square root, and the total latency.
  localparam int FRONT_STAGES = 7;
  localparam int PIPE_LAT     = FRONT_STAGES + SQRT_STAGES;

  // Fields that ride alongside the square root.
  typedef struct packed {
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic signed [COORD_W-1:0] mid_z;
    logic                      bnd;
  } side_t;

endpackage

>>> design/tac_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with side data carried along.
module tac_sqrt_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [tac_pkg::SQ_W-1:0]     radicand,
  input  tac_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [tac_pkg::ROOT_W-1:0]   root,
  output tac_pkg::side_t               out_side
);

  localparam int N = tac_pkg::SQRT_STAGES;

  // Stage registers.
  logic                         vld [N];
  logic [tac_pkg::REM_W-1:0]    rem [N];
  logic [tac_pkg::ROOT_W-1:0]   rt  [N];
  logic [tac_pkg::SQ_W-1:0]     rad [N];
  tac_pkg::side_t               sd  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                         v_in;
    logic [tac_pkg::REM_W-1:0]    rem_in;
    logic [tac_pkg::ROOT_W-1:0]   rt_in;
    logic [tac_pkg::SQ_W-1:0]     rad_in;
    tac_pkg::side_t               sd_in;
    logic [tac_pkg::REM_W:0]      cur;
    logic [tac_pkg::REM_W:0]      trial;
    logic [tac_pkg::REM_W:0]      diff;
    logic                         ge;

    // The first stage starts from an empty root and remainder.
    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign rt_in  = '0;
      assign rad_in = radicand;
      assign sd_in  = in_side;
    end else begin : g_rest
      assign v_in   = vld[i-1];
      assign rem_in = rem[i-1];
      assign rt_in  = rt[i-1];
      assign rad_in = rad[i-1];
      assign sd_in  = sd[i-1];
    end

    // Bring down the next two radicand bits and try a one in this root bit.
    // The incoming remainder never exceeds twice the partial root, so its top bit is zero.
    assign cur   = {rem_in[tac_pkg::REM_W-2:0], rad_in[tac_pkg::SQ_W-1 -: 2]};
    assign trial = {rt_in, 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem[i] <= ge ? diff[tac_pkg::REM_W-1:0] : cur[tac_pkg::REM_W-1:0];
      rt[i]  <= {rt_in[tac_pkg::ROOT_W-2:0], ge};
      rad[i] <= {rad_in[tac_pkg::SQ_W-3:0], 2'b00};
      sd[i]  <= sd_in;
    end
  end

  assign out_valid = vld[N-1];
  assign root      = rt[N-1];
  assign out_side  = sd[N-1];

endmodule

>>> design/triangle_area_centroid.sv
// Top level: triangle area by cross product and centroid, fully pipelined.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------------
//  input    | start, busy (always low) | ax ay az bx by_coord bz cx_in cy_in cz_in,
//           |                          | a_edge b_edge c_edge
//  result   | done (one-cycle strobe)  | area mid_x mid_y mid_z on_boundary
//
// One item is taken in every cycle; each item passes through seven arithmetic stages,
// then one stage per bit of the 50-bit square root.
// The square root chain of compare-and-subtract stages sets the latency.
// Reset is synchronous and clears only the valid bits; payload registers are not reset.
// Nothing stalls: busy stays low and the receiver takes every result as it appears.
module triangle_area_centroid (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tac_pkg::COORD_W-1:0] ax,
  input  logic signed [tac_pkg::COORD_W-1:0] ay,
  input  logic signed [tac_pkg::COORD_W-1:0] az,
  input  logic signed [tac_pkg::COORD_W-1:0] bx,
  input  logic signed [tac_pkg::COORD_W-1:0] by_coord,
  input  logic signed [tac_pkg::COORD_W-1:0] bz,
  input  logic signed [tac_pkg::COORD_W-1:0] cx_in,
  input  logic signed [tac_pkg::COORD_W-1:0] cy_in,
  input  logic signed [tac_pkg::COORD_W-1:0] cz_in,
  input  logic                               a_edge,
  input  logic                               b_edge,
  input  logic                               c_edge,
  output logic                               done,
  output logic        [tac_pkg::AREA_W-1:0]  area,
  output logic signed [tac_pkg::COORD_W-1:0] mid_x,
  output logic signed [tac_pkg::COORD_W-1:0] mid_y,
  output logic signed [tac_pkg::COORD_W-1:0] mid_z,
  output logic                               on_boundary
);

  // The pipeline never holds an item back.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid bits of the front stages.
  logic v1, v2, v3, v4, v5, v6, v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // Stage 1: edge vectors, coordinate sums and the boundary flag.
  logic signed [tac_pkg::EDGE_W-1:0] ux, uy, uz, wx, wy, wz;
  logic signed [tac_pkg::SUM_W-1:0]  sum_x, sum_y, sum_z;
  logic                              bnd1;

  always_ff @(posedge clk) begin
    ux    <= tac_pkg::EDGE_W'(ax) - tac_pkg::EDGE_W'(bx);
    uy    <= tac_pkg::EDGE_W'(ay) - tac_pkg::EDGE_W'(by_coord);
    uz    <= tac_pkg::EDGE_W'(az) - tac_pkg::EDGE_W'(bz);
    wx    <= tac_pkg::EDGE_W'(bx) - tac_pkg::EDGE_W'(cx_in);
    wy    <= tac_pkg::EDGE_W'(by_coord) - tac_pkg::EDGE_W'(cy_in);
    wz    <= tac_pkg::EDGE_W'(bz) - tac_pkg::EDGE_W'(cz_in);
    sum_x <= tac_pkg::SUM_W'(ax) + tac_pkg::SUM_W'(bx) + tac_pkg::SUM_W'(cx_in);
    sum_y <= tac_pkg::SUM_W'(ay) + tac_pkg::SUM_W'(by_coord) + tac_pkg::SUM_W'(cy_in);
    sum_z <= tac_pkg::SUM_W'(az) + tac_pkg::SUM_W'(bz) + tac_pkg::SUM_W'(cz_in);
    bnd1  <= a_edge & b_edge & c_edge;
  end

  // Stage 2: the six cross-product terms, and sign and magnitude of each sum.
  logic signed [tac_pkg::PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic        [tac_pkg::CMAG_W-1:0] cm_x, cm_y, cm_z;
  logic                              neg2_x, neg2_y, neg2_z;
  logic                              bnd2;
  logic        [tac_pkg::SUM_W-1:0]  abs_x, abs_y, abs_z;

  always_comb begin
    abs_x = sum_x[tac_pkg::SUM_W-1] ? -sum_x : sum_x;
    abs_y = sum_y[tac_pkg::SUM_W-1] ? -sum_y : sum_y;
    abs_z = sum_z[tac_pkg::SUM_W-1] ? -sum_z : sum_z;
  end

  always_ff @(posedge clk) begin
    p_yz   <= uy * wz;
    p_zy   <= uz * wy;
    p_zx   <= uz * wx;
    p_xz   <= ux * wz;
    p_xy   <= ux * wy;
    p_yx   <= uy * wx;
    cm_x   <= abs_x[tac_pkg::CMAG_W-1:0];
    cm_y   <= abs_y[tac_pkg::CMAG_W-1:0];
    cm_z   <= abs_z[tac_pkg::CMAG_W-1:0];
    neg2_x <= sum_x[tac_pkg::SUM_W-1];
    neg2_y <= sum_y[tac_pkg::SUM_W-1];
    neg2_z <= sum_z[tac_pkg::SUM_W-1];
    bnd2   <= bnd1;
  end

  // Stage 3: cross components, and the sum magnitudes divided by three.
  logic signed [tac_pkg::CROSS_W-1:0] kx, ky, kz;
  logic        [tac_pkg::COORD_W-1:0] q_x, q_y, q_z;
  logic                               neg3_x, neg3_y, neg3_z;
  logic                               bnd3;
  logic        [tac_pkg::QPROD_W-1:0] qp_x, qp_y, qp_z;

  always_comb begin
    qp_x = tac_pkg::QPROD_W'(cm_x) * tac_pkg::QPROD_W'(tac_pkg::RECIP_3);
    qp_y = tac_pkg::QPROD_W'(cm_y) * tac_pkg::QPROD_W'(tac_pkg::RECIP_3);
    qp_z = tac_pkg::QPROD_W'(cm_z) * tac_pkg::QPROD_W'(tac_pkg::RECIP_3);
  end

  always_ff @(posedge clk) begin
    kx     <= tac_pkg::CROSS_W'(p_yz) - tac_pkg::CROSS_W'(p_zy);
    ky     <= tac_pkg::CROSS_W'(p_zx) - tac_pkg::CROSS_W'(p_xz);
    kz     <= tac_pkg::CROSS_W'(p_xy) - tac_pkg::CROSS_W'(p_yx);
    q_x    <= qp_x[tac_pkg::RECIP_SHIFT +: tac_pkg::COORD_W];
    q_y    <= qp_y[tac_pkg::RECIP_SHIFT +: tac_pkg::COORD_W];
    q_z    <= qp_z[tac_pkg::RECIP_SHIFT +: tac_pkg::COORD_W];
    neg3_x <= neg2_x;
    neg3_y <= neg2_y;
    neg3_z <= neg2_z;
    bnd3   <= bnd2;
  end

  // Stage 4: cross magnitudes, and the signed centroid (truncated toward zero).
  logic [tac_pkg::MAG_W-1:0]   m_x, m_y, m_z;
  tac_pkg::side_t              side4, side5, side6, side7;
  logic [tac_pkg::CROSS_W-1:0] ak_x, ak_y, ak_z;

  always_comb begin
    ak_x = kx[tac_pkg::CROSS_W-1] ? -kx : kx;
    ak_y = ky[tac_pkg::CROSS_W-1] ? -ky : ky;
    ak_z = kz[tac_pkg::CROSS_W-1] ? -kz : kz;
  end

  always_ff @(posedge clk) begin
    m_x         <= ak_x[tac_pkg::MAG_W-1:0];
    m_y         <= ak_y[tac_pkg::MAG_W-1:0];
    m_z         <= ak_z[tac_pkg::MAG_W-1:0];
    side4.mid_x <= neg3_x ? -q_x : q_x;
    side4.mid_y <= neg3_y ? -q_y : q_y;
    side4.mid_z <= neg3_z ? -q_z : q_z;
    side4.bnd   <= bnd3;
  end

  // Stage 5: partial products of each square, split into upper and lower halves.
  localparam int HP_W = 2 * tac_pkg::HALF_W;
  logic [HP_W-1:0] hh_x, hl_x, ll_x, hh_y, hl_y, ll_y, hh_z, hl_z, ll_z;

  always_ff @(posedge clk) begin
    hh_x  <= HP_W'(m_x[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]) *
             HP_W'(m_x[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]);
    hl_x  <= HP_W'(m_x[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]) *
             HP_W'(m_x[tac_pkg::HALF_W-1:0]);
    ll_x  <= HP_W'(m_x[tac_pkg::HALF_W-1:0]) * HP_W'(m_x[tac_pkg::HALF_W-1:0]);
    hh_y  <= HP_W'(m_y[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]) *
             HP_W'(m_y[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]);
    hl_y  <= HP_W'(m_y[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]) *
             HP_W'(m_y[tac_pkg::HALF_W-1:0]);
    ll_y  <= HP_W'(m_y[tac_pkg::HALF_W-1:0]) * HP_W'(m_y[tac_pkg::HALF_W-1:0]);
    hh_z  <= HP_W'(m_z[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]) *
             HP_W'(m_z[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]);
    hl_z  <= HP_W'(m_z[tac_pkg::MAG_W-1 -: tac_pkg::HALF_W]) *
             HP_W'(m_z[tac_pkg::HALF_W-1:0]);
    ll_z  <= HP_W'(m_z[tac_pkg::HALF_W-1:0]) * HP_W'(m_z[tac_pkg::HALF_W-1:0]);
    side5 <= side4;
  end

  // Stage 6: assemble each square; the cross term counts twice, hence one extra shift.
  logic [tac_pkg::SQ_W-1:0] sq_x, sq_y, sq_z;

  always_ff @(posedge clk) begin
    sq_x  <= (tac_pkg::SQ_W'(hh_x) << (2 * tac_pkg::HALF_W)) +
             (tac_pkg::SQ_W'(hl_x) << (tac_pkg::HALF_W + 1)) + tac_pkg::SQ_W'(ll_x);
    sq_y  <= (tac_pkg::SQ_W'(hh_y) << (2 * tac_pkg::HALF_W)) +
             (tac_pkg::SQ_W'(hl_y) << (tac_pkg::HALF_W + 1)) + tac_pkg::SQ_W'(ll_y);
    sq_z  <= (tac_pkg::SQ_W'(hh_z) << (2 * tac_pkg::HALF_W)) +
             (tac_pkg::SQ_W'(hl_z) << (tac_pkg::HALF_W + 1)) + tac_pkg::SQ_W'(ll_z);
    side6 <= side5;
  end

  // Stage 7: squared norm of the cross product, in units of 2^-48.
  logic [tac_pkg::SQ_W-1:0] norm_sq;

  always_ff @(posedge clk) begin
    norm_sq <= sq_x + sq_y + sq_z;
    side7   <= side6;
  end

  // Square root stages; the last one holds the result.
  logic [tac_pkg::ROOT_W-1:0] root;
  tac_pkg::side_t             side_out;

  tac_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .radicand  (norm_sq),
    .in_side   (side7),
    .out_valid (done),
    .root      (root),
    .out_side  (side_out)
  );

  assign area        = tac_pkg::AREA_W'(root);
  assign mid_x       = side_out.mid_x;
  assign mid_y       = side_out.mid_y;
  assign mid_z       = side_out.mid_z;
  assign on_boundary = side_out.bnd;

`ifndef SYNTHESIS
  // No result comes out in the cycle after a reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // Every accepted item gives a result exactly the pipeline latency later.
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(tac_pkg::PIPE_LAT) done)
    else $error("accepted item produced no result");

  // Every result traces back to an accepted item.
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, tac_pkg::PIPE_LAT))
    else $error("result without an accepted item");

  // The boundary flag follows the flags of the same item.
  a_boundary_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (on_boundary == $past(a_edge && b_edge && c_edge, tac_pkg::PIPE_LAT)))
    else $error("boundary flag out of step with its item");

  // A triangle whose vertices coincide has zero area.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(ax == bx && bx == cx_in && ay == by_coord && by_coord == cy_in &&
                  az == bz && bz == cz_in, tac_pkg::PIPE_LAT) |-> (area == '0))
    else $error("coincident vertices gave non-zero area");
`endif

endmodule

>>> sim/tb_triangle_area_centroid.sv
// Self-checking testbench for the triangle area and centroid pipeline.
`timescale 1ns / 1ps

module tb_triangle_area_centroid;

  localparam int COORD_W  = tac_pkg::COORD_W;
  localparam int AREA_W   = tac_pkg::AREA_W;
  localparam int PIPE_LAT = tac_pkg::PIPE_LAT;

  localparam int RANDOM_ITEMS   = 830;
  localparam int STALL_LIMIT    = 2000;
  localparam int SHOW_LIMIT     = 10;
  localparam int IDLE_LIGHT_PCT = 14;
  localparam int IDLE_HEAVY_PCT = 85;
  localparam int IDLE_NONE_PCT  = 0;

  localparam logic signed [COORD_W-1:0] C_MAX  = 24'h7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN  = 24'h800000;
  localparam logic signed [COORD_W-1:0] C_ZERO = 24'h000000;
  localparam logic signed [COORD_W-1:0] C_ONE  = 24'h001000;  // 1.0 in Q12.12
  localparam logic signed [COORD_W-1:0] C_A5   = 24'h555555;
  localparam logic signed [COORD_W-1:0] C_AA   = 24'hAAAAAA;

  // Shapes of random triangle.
  typedef enum int {
    SHAPE_FULL, SHAPE_SMALL, SHAPE_EXTREME, SHAPE_COLLINEAR, SHAPE_COINCIDENT
  } shape_t;

  typedef struct {
    logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [2:0]                flags;  // {c, b, a} boundary flags
  } triangle_t;

  typedef struct {
    logic        [AREA_W-1:0]  area;
    logic signed [COORD_W-1:0] mid_x, mid_y, mid_z;
    logic                      on_boundary;
  } summary_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [COORD_W-1:0] ax = '0, ay = '0, az = '0;
  logic signed [COORD_W-1:0] bx = '0, by_coord = '0, bz = '0;
  logic signed [COORD_W-1:0] cx_in = '0, cy_in = '0, cz_in = '0;
  logic a_edge = 1'b0, b_edge = 1'b0, c_edge = 1'b0;
  logic busy, done, on_boundary;
  logic        [AREA_W-1:0]  area;
  logic signed [COORD_W-1:0] mid_x, mid_y, mid_z;

  triangle_t pending_triangles[$];
  summary_t  expected_summaries[$];
  triangle_t presented;
  int        total_triangles;
  int        triangles_sent = 0;
  int        fault_count = 0;
  int        stall_cycles = 0;
  int        idle_pct;

  triangle_area_centroid DUT (
    .clk, .rst, .start, .busy,
    .ax, .ay, .az, .bx, .by_coord, .bz, .cx_in, .cy_in, .cz_in,
    .a_edge, .b_edge, .c_edge,
    .done, .area, .mid_x, .mid_y, .mid_z, .on_boundary
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Area from the exact squared norm of the cross product, centroid by truncating division.
  function automatic summary_t triangle_summary(triangle_t t);
    longint ux, uy, uz, wx, wy, wz, kx, ky, kz;
    logic [49:0]  mx, my, mz;
    logic [101:0] norm_sq;
    logic [50:0]  root, cand;
    summary_t     s;
    ux = longint'(t.ax) - longint'(t.bx);
    uy = longint'(t.ay) - longint'(t.by);
    uz = longint'(t.az) - longint'(t.bz);
    wx = longint'(t.bx) - longint'(t.cx);
    wy = longint'(t.by) - longint'(t.cy);
    wz = longint'(t.bz) - longint'(t.cz);
    kx = uy * wz - uz * wy;
    ky = uz * wx - ux * wz;
    kz = ux * wy - uy * wx;
    mx = (kx < 0) ? 50'(-kx) : 50'(kx);
    my = (ky < 0) ? 50'(-ky) : 50'(ky);
    mz = (kz < 0) ? 50'(-kz) : 50'(kz);
    norm_sq = 102'(mx) * 102'(mx) + 102'(my) * 102'(my) + 102'(mz) * 102'(mz);
    root = '0;
    for (int bit_idx = 50; bit_idx >= 0; bit_idx--) begin
      cand = root | (51'd1 << bit_idx);
      if (102'(cand) * 102'(cand) <= norm_sq)
        root = cand;
    end
    s.area  = root[AREA_W-1:0];
    s.mid_x = COORD_W'((longint'(t.ax) + longint'(t.bx) + longint'(t.cx)) / 3);
    s.mid_y = COORD_W'((longint'(t.ay) + longint'(t.by) + longint'(t.cy)) / 3);
    s.mid_z = COORD_W'((longint'(t.az) + longint'(t.bz) + longint'(t.cz)) / 3);
    s.on_boundary = &t.flags;
    return s;
  endfunction

  function automatic triangle_t make_triangle(
    input logic signed [COORD_W-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3,
    input logic [2:0] flags);
    triangle_t t;
    t.ax = x1; t.ay = y1; t.az = z1;
    t.bx = x2; t.by = y2; t.bz = z2;
    t.cx = x3; t.cy = y3; t.cz = z3;
    t.flags = flags;
    return t;
  endfunction

  // A coordinate near 0 so that sums and steps stay well inside range.
  function automatic logic signed [COORD_W-1:0] small_coord();
    return COORD_W'(int'($urandom_range(16383)) - 8192);
  endfunction

  function automatic logic signed [COORD_W-1:0] corner_coord();
    case ($urandom_range(5))
      0: return C_MAX;
      1: return C_MIN;
      2: return C_ZERO;
      3: return -24'sd1;
      4: return 24'sd1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic triangle_t random_triangle();
    shape_t    shape;
    triangle_t t;
    int        pick;
    logic signed [COORD_W-1:0] dx, dy, dz;
    pick = $urandom_range(9);
    shape = (pick < 4) ? SHAPE_FULL : (pick < 6) ? SHAPE_SMALL :
            (pick < 8) ? SHAPE_EXTREME : (pick < 9) ? SHAPE_COLLINEAR : SHAPE_COINCIDENT;
    t.flags = 3'($urandom);
    case (shape)
      SHAPE_FULL, SHAPE_COINCIDENT: begin
        t.ax = COORD_W'($urandom); t.ay = COORD_W'($urandom); t.az = COORD_W'($urandom);
        t.bx = COORD_W'($urandom); t.by = COORD_W'($urandom); t.bz = COORD_W'($urandom);
        t.cx = COORD_W'($urandom); t.cy = COORD_W'($urandom); t.cz = COORD_W'($urandom);
        // Collapse one vertex onto another.
        if (shape == SHAPE_COINCIDENT) begin
          if ($urandom_range(1)) begin
            t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
          end else begin
            t.bx = t.cx; t.by = t.cy; t.bz = t.cz;
          end
        end
      end
      SHAPE_SMALL: begin
        t.ax = small_coord(); t.ay = small_coord(); t.az = small_coord();
        t.bx = small_coord(); t.by = small_coord(); t.bz = small_coord();
        t.cx = small_coord(); t.cy = small_coord(); t.cz = small_coord();
      end
      SHAPE_EXTREME: begin
        t.ax = corner_coord(); t.ay = corner_coord(); t.az = corner_coord();
        t.bx = corner_coord(); t.by = corner_coord(); t.bz = corner_coord();
        t.cx = corner_coord(); t.cy = corner_coord(); t.cz = corner_coord();
      end
      default: begin
        // Three points evenly spaced along one line.
        t.ax = small_coord(); t.ay = small_coord(); t.az = small_coord();
        dx = small_coord(); dy = small_coord(); dz = small_coord();
        t.bx = t.ax + dx; t.by = t.ay + dy; t.bz = t.az + dz;
        t.cx = t.bx + dx; t.cy = t.by + dy; t.cz = t.bz + dz;
      end
    endcase
    return t;
  endfunction

  // Driver: presents the queued items, idling at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_summaries.push_back(triangle_summary(presented));
      if (!start || !busy) begin
        idle_pct = (triangles_sent < total_triangles / 3) ? IDLE_LIGHT_PCT :
                   (triangles_sent < 2 * total_triangles / 3) ? IDLE_HEAVY_PCT : IDLE_NONE_PCT;
        if (pending_triangles.size() != 0 && $urandom_range(99) >= idle_pct) begin
          presented = pending_triangles.pop_front();
          triangles_sent++;
          ax <= presented.ax; ay <= presented.ay; az <= presented.az;
          bx <= presented.bx; by_coord <= presented.by; bz <= presented.bz;
          cx_in <= presented.cx; cy_in <= presented.cy; cz_in <= presented.cz;
          a_edge <= presented.flags[0];
          b_edge <= presented.flags[1];
          c_edge <= presented.flags[2];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result is checked against the oldest expectation.
  always @(posedge clk) begin
    summary_t want;
    if (!rst && done) begin
      if (expected_summaries.size() == 0) begin
        if (fault_count < SHOW_LIMIT)
          $display("%0t: result with no item outstanding: area=%0d mid=(%0d,%0d,%0d) bnd=%0b",
                   $realtime, area, mid_x, mid_y, mid_z, on_boundary);
        fault_count++;
      end else begin
        want = expected_summaries.pop_front();
        if (area !== want.area || mid_x !== want.mid_x || mid_y !== want.mid_y ||
            mid_z !== want.mid_z || on_boundary !== want.on_boundary) begin
          if (fault_count < SHOW_LIMIT) begin
            $display("%0t: mismatch, expected area=%0d mid=(%0d,%0d,%0d) bnd=%0b",
                     $realtime, want.area, want.mid_x, want.mid_y, want.mid_z,
                     want.on_boundary);
            $display("%0t:           got      area=%0d mid=(%0d,%0d,%0d) bnd=%0b",
                     $realtime, area, mid_x, mid_y, mid_z, on_boundary);
          end
          fault_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_triangle_area_centroid: done, errors");
      $finish;
    end
  end

  initial begin
    // Directed triangles: extremes, degenerate shapes, rounding of the centroid.
    pending_triangles.push_back(make_triangle(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                                              C_ZERO, C_ZERO, C_ZERO, C_ZERO, 3'b000));
    pending_triangles.push_back(make_triangle(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                              C_MAX, C_MAX, C_MAX, 3'b111));
    pending_triangles.push_back(make_triangle(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                              C_MIN, C_MIN, C_MIN, 3'b111));
    pending_triangles.push_back(make_triangle(C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO,
                                              C_ZERO, C_ONE, C_ZERO, 3'b001));
    pending_triangles.push_back(make_triangle(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                                              C_MAX, C_MAX, C_MIN, 3'b010));
    pending_triangles.push_back(make_triangle(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN,
                                              C_MIN, C_MAX, C_MIN, 3'b100));
    pending_triangles.push_back(make_triangle(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                                              C_MIN, C_MAX, C_MAX, 3'b011));
    pending_triangles.push_back(make_triangle(C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                                              C_MIN, C_MIN, C_MAX, 3'b110));
    pending_triangles.push_back(make_triangle(C_ZERO, C_ZERO, C_ZERO, 24'sd4096, 24'sd8192,
                                              -24'sd4096, 24'sd8192, 24'sd16384, -24'sd8192,
                                              3'b101));
    pending_triangles.push_back(make_triangle(24'sd1234, -24'sd5678, 24'sd91011, 24'sd1234,
                                              -24'sd5678, 24'sd91011, 24'sd1234, -24'sd5678,
                                              24'sd91011, 3'b110));
    pending_triangles.push_back(make_triangle(C_MAX, C_MIN, -24'sd1, C_MAX, C_MIN, -24'sd1,
                                              C_MIN, C_MAX, C_ZERO, 3'b011));
    pending_triangles.push_back(make_triangle(-24'sd1, -24'sd2, -24'sd4, C_ZERO, C_ZERO,
                                              -24'sd1, C_ZERO, C_ZERO, C_ZERO, 3'b111));
    pending_triangles.push_back(make_triangle(24'sd1, 24'sd2, 24'sd4, C_ZERO, C_ZERO, 24'sd1,
                                              C_ZERO, C_ZERO, C_ZERO, 3'b000));
    pending_triangles.push_back(make_triangle(C_A5, C_AA, C_A5, C_AA, C_A5, C_AA, C_A5, C_A5,
                                              C_AA, 3'b101));
    pending_triangles.push_back(make_triangle(C_AA, C_A5, C_AA, C_A5, C_AA, C_A5, C_AA, C_AA,
                                              C_A5, 3'b010));
    // The smallest non-degenerate triangles, then one spanning the full coordinate range.
    pending_triangles.push_back(make_triangle(C_ZERO, C_ZERO, C_ZERO, 24'sd1, C_ZERO, C_ZERO,
                                              C_ZERO, 24'sd1, C_ZERO, 3'b110));
    pending_triangles.push_back(make_triangle(C_ZERO, C_ZERO, C_ZERO, C_ZERO, -24'sd1, C_ZERO,
                                              C_ZERO, C_ZERO, -24'sd1, 3'b001));
    pending_triangles.push_back(make_triangle(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                                              C_MAX, C_MIN, C_ZERO, 3'b100));
    for (int i = 0; i < RANDOM_ITEMS; i++)
      pending_triangles.push_back(random_triangle());
    total_triangles = pending_triangles.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken, then for every result to come back.
    while (pending_triangles.size() != 0 || start)
      @(posedge clk);
    while (expected_summaries.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);

    if (fault_count == 0)
      $display("tb_triangle_area_centroid: done, clean");
    else
      $display("tb_triangle_area_centroid: done, errors");
    $finish;
  end

endmodule
